// ===== sv/ipr_pkg.sv =====
// shared widths, request/result structs for the incremental pivot rotation unit
package ipr_pkg;

  localparam int COORD_W   = 10;  // vertex and pivot coordinate width
  localparam int TRIG_W    = 16;  // q1.15 sine/cosine width
  localparam int TRIG_BITS = 15;  // fraction bits of the trig table
  localparam int OFF_W     = 32;  // translation offset width
  localparam int ROT_W     = 28;  // c*x - s*y with 10-bit coords
  localparam int OUT_W     = 12;  // result coordinate width
  localparam int OUT_MAX   = 2047;
  localparam int OUT_MIN   = -2048;

  // one vertex request as it sits in the input register
  typedef struct packed {
    logic               frame_start;
    logic [COORD_W-1:0] pivot_x;
    logic [COORD_W-1:0] pivot_y;
    logic [COORD_W-1:0] orig_x;
    logic [COORD_W-1:0] orig_y;
  } vertex_req_t;

  // rotated vertex terms and the offset that goes with them
  typedef struct packed {
    logic signed [ROT_W-1:0] rot_x;
    logic signed [ROT_W-1:0] rot_y;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
  } xform_t;

  // finished result
  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic                    clipped;
  } vertex_res_t;

endpackage

// ===== sv/ipr_rotate.sv =====
// offset/angle state, trig table lookup and the vertex rotation products
module ipr_rotate #(
  parameter int ANGLE_STEPS = 72,
  parameter int FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,    // request leaves the input register
  input  ipr_pkg::vertex_req_t req_i,
  output ipr_pkg::xform_t      xform_o
);
  import ipr_pkg::*;

  localparam int AW = $clog2(ANGLE_STEPS);
  localparam int TAB_N = 2 ** AW;
  // offset minus pivot, pivot scaled up by FRAC_BITS
  localparam int DW = (FRAC_BITS + 12 > 33) ? FRAC_BITS + 12 : 33;
  localparam int PW = DW + TRIG_W + 1;
  localparam int NW = DW + 3;
  localparam longint Q30_ONE = 64'sd1 <<< 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [NW-1:0] OFF_HI = NW'(64'sd2147483647);
  localparam logic signed [NW-1:0] OFF_LO = NW'(-64'sd2147483648);

  // (v*r*r) in q30, truncating after each product
  function automatic longint sq_step(longint v, longint r);
    return (((v * r) / Q30_ONE) * r) / Q30_ONE;
  endfunction

  // q1.15 sine or cosine of 2*pi*k/ANGLE_STEPS, evaluated at elaboration
  function automatic logic signed [TRIG_W-1:0] trig_q15(int k, bit want_sin);
    longint theta, q, r, ts, tc, ss, cs, so, co, v, m;
    theta = (longint'(k) * 4 * HALF_PI_Q30) / ANGLE_STEPS;
    q = theta / HALF_PI_Q30;
    r = theta - q * HALF_PI_Q30;
    ts = r;
    tc = Q30_ONE;
    ss = r;
    cs = Q30_ONE;
    ts = -sq_step(ts, r) / 6;   tc = -sq_step(tc, r) / 2;   ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 20;  tc = -sq_step(tc, r) / 12;  ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 42;  tc = -sq_step(tc, r) / 30;  ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 72;  tc = -sq_step(tc, r) / 56;  ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 110; tc = -sq_step(tc, r) / 90;  ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 156; tc = -sq_step(tc, r) / 132; ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 210; tc = -sq_step(tc, r) / 182; ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 272; tc = -sq_step(tc, r) / 240; ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 342; tc = -sq_step(tc, r) / 306; ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 420; tc = -sq_step(tc, r) / 380; ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 506; tc = -sq_step(tc, r) / 462; ss += ts; cs += tc;
    ts = -sq_step(ts, r) / 600; tc = -sq_step(tc, r) / 552; ss += ts; cs += tc;
    case (q[1:0])
      2'd0: begin
        so = ss;
        co = cs;
      end
      2'd1: begin
        so = cs;
        co = -ss;
      end
      2'd2: begin
        so = -ss;
        co = -cs;
      end
      default: begin
        so = -cs;
        co = ss;
      end
    endcase
    v = want_sin ? so : co;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< 14)) >>> 15;
    if (m > 32767) m = 32767;
    if (v < 0) m = -m;
    return TRIG_W'(m);
  endfunction

  localparam logic signed [TRIG_W-1:0] COS_STEP = trig_q15(1, 1'b0);
  localparam logic signed [TRIG_W-1:0] SIN_STEP = trig_q15(1, 1'b1);

  logic signed [TRIG_W-1:0] sin_rom [TAB_N];
  logic signed [TRIG_W-1:0] cos_rom [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_rom
    if (k < ANGLE_STEPS) begin : g_used
      assign sin_rom[k] = trig_q15(k, 1'b1);
      assign cos_rom[k] = trig_q15(k, 1'b0);
    end else begin : g_pad
      assign sin_rom[k] = '0;
      assign cos_rom[k] = '0;
    end
  end

  logic signed [OFF_W-1:0] offset_x_q, offset_x_d;
  logic signed [OFF_W-1:0] offset_y_q, offset_y_d;
  logic [AW-1:0]           angle_q, angle_d;

  logic signed [DW-1:0] pxf, pyf, dx, dy;
  logic signed [PW-1:0] rx, ry;
  logic signed [NW-1:0] nx, ny;
  logic                 step;

  function automatic logic signed [OFF_W-1:0] sat_off(logic signed [NW-1:0] v);
    if (v > OFF_HI) return OFF_W'(OFF_HI);
    if (v < OFF_LO) return OFF_W'(OFF_LO);
    return OFF_W'(v);
  endfunction

  assign step = adv_i & req_i.frame_start;

  // rotate the offset about the pivot by one angle step
  assign pxf = {{(DW-COORD_W-FRAC_BITS){1'b0}}, req_i.pivot_x, {FRAC_BITS{1'b0}}};
  assign pyf = {{(DW-COORD_W-FRAC_BITS){1'b0}}, req_i.pivot_y, {FRAC_BITS{1'b0}}};
  assign dx  = {{(DW-OFF_W){offset_x_q[OFF_W-1]}}, offset_x_q} - pxf;
  assign dy  = {{(DW-OFF_W){offset_y_q[OFF_W-1]}}, offset_y_q} - pyf;
  assign rx  = PW'(COS_STEP) * PW'(dx) - PW'(SIN_STEP) * PW'(dy);
  assign ry  = PW'(SIN_STEP) * PW'(dx) + PW'(COS_STEP) * PW'(dy);
  assign nx  = NW'(rx >>> TRIG_BITS) + NW'(pxf);
  assign ny  = NW'(ry >>> TRIG_BITS) + NW'(pyf);

  always_comb begin
    offset_x_d = offset_x_q;
    offset_y_d = offset_y_q;
    angle_d    = angle_q;
    if (req_i.frame_start) begin
      offset_x_d = sat_off(nx);
      offset_y_d = sat_off(ny);
      angle_d    = (angle_q == AW'(ANGLE_STEPS - 1)) ? '0 : angle_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      angle_q    <= '0;
    end else if (step) begin
      offset_x_q <= offset_x_d;
      offset_y_q <= offset_y_d;
      angle_q    <= angle_d;
    end
  end

  // rotate the vertex by the (possibly advanced) angle
  logic signed [TRIG_W-1:0]  cs_c, cs_s;
  logic signed [COORD_W:0]   oxs, oys;

  assign cs_c = cos_rom[angle_d];
  assign cs_s = sin_rom[angle_d];
  assign oxs  = {1'b0, req_i.orig_x};
  assign oys  = {1'b0, req_i.orig_y};

  assign xform_o.rot_x = ROT_W'(cs_c) * ROT_W'(oxs) - ROT_W'(cs_s) * ROT_W'(oys);
  assign xform_o.rot_y = ROT_W'(cs_s) * ROT_W'(oxs) + ROT_W'(cs_c) * ROT_W'(oys);
  assign xform_o.off_x = offset_x_d;
  assign xform_o.off_y = offset_y_d;

`ifndef NO_ASSERTIONS
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q <= AW'(ANGLE_STEPS - 1))
    else $error("angle index out of range");

  a_angle_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && angle_q == AW'(ANGLE_STEPS - 1) |=> angle_q == '0)
    else $error("angle index did not wrap");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(angle_q) && $stable(offset_x_q) && $stable(offset_y_q))
    else $error("rotation state moved without a frame start");
`endif

endmodule

// ===== sv/ipr_vertex_out.sv =====
// final translate, truncate toward zero and saturate of one rotated vertex
module ipr_vertex_out #(
  parameter int FRAC_BITS = 16
) (
  input  ipr_pkg::xform_t      xform_i,
  output ipr_pkg::vertex_res_t res_o
);
  import ipr_pkg::*;

  localparam int SHIFT = FRAC_BITS + TRIG_BITS;
  localparam int SW = ((ROT_W + FRAC_BITS > OFF_W + TRIG_BITS) ?
                       ROT_W + FRAC_BITS : OFF_W + TRIG_BITS) + 1;
  localparam int QW = SW - SHIFT;
  localparam logic signed [SW-1:0] BIAS = {{QW{1'b0}}, {SHIFT{1'b1}}};
  localparam logic signed [QW-1:0] QMAX = QW'(OUT_MAX);
  localparam logic signed [QW-1:0] QMIN = QW'(OUT_MIN);

  // returns {clip, value}
  function automatic logic [OUT_W:0] scale_sat(logic signed [SW-1:0] sum);
    logic signed [SW-1:0] b;
    logic signed [QW-1:0] q;
    b = sum + (sum[SW-1] ? BIAS : '0);
    q = b[SW-1:SHIFT];
    if (q > QMAX) return {1'b1, OUT_W'(OUT_MAX)};
    if (q < QMIN) return {1'b1, OUT_W'(OUT_MIN)};
    return {1'b0, q[OUT_W-1:0]};
  endfunction

  logic signed [SW-1:0] sum_x, sum_y;
  logic [OUT_W:0]       sx, sy;

  assign sum_x = (SW'(xform_i.rot_x) <<< FRAC_BITS) + (SW'(xform_i.off_x) <<< TRIG_BITS);
  assign sum_y = (SW'(xform_i.rot_y) <<< FRAC_BITS) + (SW'(xform_i.off_y) <<< TRIG_BITS);
  assign sx    = scale_sat(sum_x);
  assign sy    = scale_sat(sum_y);

  assign res_o.out_x   = sx[OUT_W-1:0];
  assign res_o.out_y   = sy[OUT_W-1:0];
  assign res_o.clipped = sx[OUT_W] | sy[OUT_W];

endmodule

// ===== sv/incremental_pivot_rotation_unit.sv =====
// top level: vertex stream in, rotated and translated vertex stream out
// incremental pivot rotation unit. each request carries one polygon vertex and a
// pivot; a request with the frame-start flag (s_axis_tuser) first rotates the stored
// translation offset about that pivot by one angle step (2*pi/ANGLE_STEPS) and
// advances the angle index, then every vertex is rotated about the origin by the
// current angle and shifted by the offset. results are truncated toward zero and
// clamped to 12-bit signed; m_axis_tuser flags a clamped coordinate. the block takes
// one request per cycle while the output is not stalled; a request passes the input
// register, product register and result register. the offset/angle update is a
// combinational loop around the offset registers (one multiply-add on the input
// register contents), so a frame-start request can be followed by another in the
// next cycle. the sine/cosine table holds ANGLE_STEPS constant entries, zero-padded to a
// power of two. when all three registers are full, s_axis_tready follows m_axis_tready.
module incremental_pivot_rotation_unit #(
  parameter int ANGLE_STEPS = 72,  // angle steps per full turn
  parameter int FRAC_BITS   = 16   // fraction bits of the stored offset
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // pivot_x, pivot_y, orig_x, orig_y
  input  logic        s_axis_tuser_i,   // frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // out_x, out_y
  output logic        m_axis_tuser_o    // clipped
);
  import ipr_pkg::*;

  // pipeline registers
  logic        s0_valid_q;
  vertex_req_t s0_req_q;
  logic        s1_valid_q;
  xform_t      s1_xf_q;
  logic        out_valid_q;
  vertex_res_t out_res_q;

  logic        out_en, s1_en, s0_en, adv;
  xform_t      xf;
  vertex_res_t res;

  // a stage may load when it is empty or its contents move on this cycle
  assign out_en = !out_valid_q || m_axis_tready_i;
  assign s1_en  = !s1_valid_q || out_en;
  assign s0_en  = !s0_valid_q || s1_en;
  assign adv    = s0_valid_q && s1_en;

  assign s_axis_tready_o = s0_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_en)  s0_valid_q  <= s_axis_tvalid_i;
      if (s1_en)  s1_valid_q  <= s0_valid_q;
      if (out_en) out_valid_q <= s1_valid_q;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s0_en) begin
      s0_req_q.frame_start <= s_axis_tuser_i;
      s0_req_q.pivot_x     <= s_axis_tdata_i[9:0];
      s0_req_q.pivot_y     <= s_axis_tdata_i[19:10];
      s0_req_q.orig_x      <= s_axis_tdata_i[29:20];
      s0_req_q.orig_y      <= s_axis_tdata_i[39:30];
    end
    if (adv) s1_xf_q <= xf;
    if (s1_valid_q && out_en) out_res_q <= res;
  end

  // offset/angle state and rotation products
  ipr_rotate #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .req_i   (s0_req_q),
    .xform_o (xf)
  );

  // translate, truncate and clamp
  ipr_vertex_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_vertex_out (
    .xform_i (s1_xf_q),
    .res_o   (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.out_y, out_res_q.out_x};
  assign m_axis_tuser_o  = out_res_q.clipped;

`ifndef NO_ASSERTIONS
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !s1_valid_q |=> s1_valid_q)
    else $error("request lost between input and product register");

  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("request lost between product and result register");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");
`endif

endmodule

// ===== test/incremental_pivot_rotation_unit_tb.sv =====
// testbench for the incremental pivot rotation unit: random stream traffic checked against a predictor
module incremental_pivot_rotation_unit_tb;
  import ipr_pkg::*;

  localparam int ANGLE_STEPS  = 72;
  localparam int FRAC_BITS    = 16;
  localparam int N_ITEMS      = 1450;  // rough size of the request stream
  localparam int MIX_ITEMS    = 520;   // directed plus random frames before the outward spiral
  localparam int SPIRAL_CAP   = 950;   // most frames spent pushing the offset outward
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
  localparam int QUIET_TAIL   = 150;   // last requests/results run with no idling
  localparam int DRAIN_CYCLES = 10;    // extra cycles run after the last result
  localparam int HOLD_AT      = 400;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES  = 80;

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TRIG_ONE    = 64'sd32767;
  localparam longint INT32_HI    = 64'sd2147483647;
  localparam longint INT32_LO    = -64'sd2147483648;
  localparam logic [COORD_W-1:0] C_MAX = '1;

  // offset and angle carried from one frame to the next
  typedef struct {
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic [6:0]              angle_idx;
  } pose_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tuser;

  // sin/cos in q1.15, entry k for angle 2*pi*k/ANGLE_STEPS
  longint sin_q15 [ANGLE_STEPS];
  longint cos_q15 [ANGLE_STEPS];

  vertex_req_t vertex_q[$];           // requests waiting to be offered
  vertex_res_t expected_vertices[$];  // predicted results in request order
  vertex_req_t cur_req;               // request currently on the slave side
  pose_t       live_pose;             // pose advanced on accepted requests
  pose_t       plan_pose;             // pose advanced while building the stream
  bit          plan_clamped;

  int n_items   = 0;
  int n_sent    = 0;
  int n_rcv     = 0;
  int n_fail    = 0;
  int n_frames  = 0;
  int n_clamps  = 0;
  int n_clipped = 0;
  int src_gap   = 0;
  int sink_gap  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_cycles = 0;

  incremental_pivot_rotation_unit #(
    .ANGLE_STEPS(ANGLE_STEPS),
    .FRAC_BITS  (FRAC_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),    // pivot_x, pivot_y, orig_x, orig_y
    .s_axis_tuser_i (s_tuser),    // frame_start
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),    // out_x, out_y
    .m_axis_tuser_o (m_tuser)     // clipped
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // q30 fraction to q1.15, rounding half away from zero, 1.0 held at 32767
  function automatic longint q30_to_q15(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< 14)) >>> 15;
    if (m > TRIG_ONE) m = TRIG_ONE;
    return (v < 0) ? -m : m;
  endfunction

  // taylor series of sin and cos for 0 <= r < pi/2, all in q30
  function automatic void trig_series(input longint r, output longint sv, output longint cv);
    longint ts, tc;
    ts = r;
    tc = Q30_ONE;
    sv = r;
    cv = Q30_ONE;
    for (int n = 1; n <= 12; n++) begin
      ts = (ts * r) / Q30_ONE;
      ts = (ts * r) / Q30_ONE;
      ts = -ts / longint'((2 * n) * (2 * n + 1));
      tc = (tc * r) / Q30_ONE;
      tc = (tc * r) / Q30_ONE;
      tc = -tc / longint'((2 * n - 1) * (2 * n));
      sv += ts;
      cv += tc;
    end
  endfunction

  function automatic void build_trig_table();
    longint theta, quad, r, s, c;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      theta = (longint'(k) * 4 * HALF_PI_Q30) / ANGLE_STEPS;
      quad  = theta / HALF_PI_Q30;
      r     = theta - quad * HALF_PI_Q30;
      trig_series(r, s, c);
      // fold the quadrant back in
      case (quad[1:0])
        2'd0: begin sin_q15[k] = q30_to_q15(s);  cos_q15[k] = q30_to_q15(c);  end
        2'd1: begin sin_q15[k] = q30_to_q15(c);  cos_q15[k] = q30_to_q15(-s); end
        2'd2: begin sin_q15[k] = q30_to_q15(-s); cos_q15[k] = q30_to_q15(-c); end
        default: begin sin_q15[k] = q30_to_q15(-c); cos_q15[k] = q30_to_q15(s); end
      endcase
    end
  endfunction

  function automatic longint clamp_off(input longint v, inout bit hit);
    if (v > INT32_HI) begin hit = 1'b1; return INT32_HI; end
    if (v < INT32_LO) begin hit = 1'b1; return INT32_LO; end
    return v;
  endfunction

  function automatic longint clamp_out(input longint v, inout logic hit);
    if (v > OUT_MAX) begin hit = 1'b1; return OUT_MAX; end
    if (v < OUT_MIN) begin hit = 1'b1; return OUT_MIN; end
    return v;
  endfunction

  // one vertex: optional pivot step of the offset, then rotate and translate
  function automatic vertex_res_t rotate_step(inout pose_t p, input vertex_req_t rq,
                                              output bit off_hit);
    longint pxf, pyf, dx, dy, c, s, ox, oy, vx, vy;
    vertex_res_t res;
    off_hit = 1'b0;
    res.clipped = 1'b0;
    if (rq.frame_start) begin
      pxf = longint'(rq.pivot_x);
      pyf = longint'(rq.pivot_y);
      pxf = pxf <<< FRAC_BITS;
      pyf = pyf <<< FRAC_BITS;
      dx  = longint'(p.off_x) - pxf;
      dy  = longint'(p.off_y) - pyf;
      c   = cos_q15[1];
      s   = sin_q15[1];
      // arithmetic shift floors, as the offset update wants
      p.off_x = OFF_W'(clamp_off(((c * dx - s * dy) >>> TRIG_BITS) + pxf, off_hit));
      p.off_y = OFF_W'(clamp_off(((s * dx + c * dy) >>> TRIG_BITS) + pyf, off_hit));
      p.angle_idx = 7'((p.angle_idx + 7'd1) % ANGLE_STEPS);
    end
    c  = cos_q15[p.angle_idx];
    s  = sin_q15[p.angle_idx];
    ox = longint'(rq.orig_x);
    oy = longint'(rq.orig_y);
    vx = (c * ox - s * oy) * (64'sd1 <<< FRAC_BITS) + longint'(p.off_x) * (64'sd1 <<< TRIG_BITS);
    vy = (s * ox + c * oy) * (64'sd1 <<< FRAC_BITS) + longint'(p.off_y) * (64'sd1 <<< TRIG_BITS);
    // signed divide truncates toward zero
    vx = clamp_out(vx / (64'sd1 <<< (FRAC_BITS + TRIG_BITS)), res.clipped);
    vy = clamp_out(vy / (64'sd1 <<< (FRAC_BITS + TRIG_BITS)), res.clipped);
    res.out_x = vx[OUT_W-1:0];
    res.out_y = vy[OUT_W-1:0];
    return res;
  endfunction

  // coordinates lean toward the edges of the range
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return C_MAX;
      default: return COORD_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic vertex_req_t make_req(input int fs, input int px, input int py,
                                           input int ox, input int oy);
    vertex_req_t rq;
    rq.frame_start = fs[0];
    rq.pivot_x     = COORD_W'(px);
    rq.pivot_y     = COORD_W'(py);
    rq.orig_x      = COORD_W'(ox);
    rq.orig_y      = COORD_W'(oy);
    return rq;
  endfunction

  // idling off in the last part of the run and in every third window
  function automatic bit idle_allowed(input int done);
    return (done < n_items - QUIET_TAIL) && ((done / 160) % 3 != 2);
  endfunction

  task automatic queue_req(input vertex_req_t rq);
    vertex_res_t unused;
    unused = rotate_step(plan_pose, rq, plan_clamped);
    vertex_q.push_back(rq);
  endtask

  // a polygon: frame start on the first vertex, pivot ignored on the rest
  task automatic add_random_frame();
    int          len;
    vertex_req_t rq;
    len = $urandom_range(1, 8);
    for (int v = 0; v < len; v++) begin
      rq.pivot_x     = rand_coord();
      rq.pivot_y     = rand_coord();
      rq.orig_x      = rand_coord();
      rq.orig_y      = rand_coord();
      // now and then a frame runs on without a frame start
      rq.frame_start = (v == 0) && ($urandom_range(0, 9) != 0);
      queue_req(rq);
    end
  endtask

  // build the stream, release reset, wait for the last result
  initial begin
    vertex_req_t trial_req, best_req;
    pose_t       trial;
    bit          hit, sat_seen;
    int          sat_tail;
    longint      score, best_score, ax, ay;
    vertex_res_t unused;

    build_trig_table();
    plan_pose = '{off_x: '0, off_y: '0, angle_idx: '0};
    live_pose = plan_pose;

    // directed: extremes, pivot about origin, back-to-back frames, far pivot until clipping
    queue_req(make_req(0, 0, 0, 0, 0));
    queue_req(make_req(0, 1023, 1023, 1023, 1023));
    queue_req(make_req(0, 0, 0, 1023, 0));
    queue_req(make_req(0, 0, 0, 0, 1023));
    queue_req(make_req(1, 0, 0, 512, 512));
    queue_req(make_req(1, 0, 0, 1023, 1023));
    queue_req(make_req(1, 1023, 1023, 0, 0));
    for (int i = 0; i < 6; i++) queue_req(make_req(1, 1023, 1023, 1023, 1023));
    queue_req(make_req(0, 0, 0, 1023, 1023));
    queue_req(make_req(1, 1023, 0, 0, 0));
    queue_req(make_req(1, 0, 1023, 1023, 0));
    queue_req(make_req(0, 1023, 0, 0, 1023));
    for (int i = 0; i < 4; i++) queue_req(make_req(1, 0, 0, 0, 0));

    while (vertex_q.size() < MIX_ITEMS) add_random_frame();

    // spiral: each frame picks the pivot that pushes the offset farthest out,
    // until the offset clamps at the 32-bit bounds and has turned a while longer
    sat_seen = 1'b0;
    sat_tail = 0;
    for (int step = 0; step < SPIRAL_CAP && sat_tail < 60; step++) begin
      best_score = -1;
      for (int k = 0; k < 8; k++) begin
        trial_req = make_req(1, 0, 0, 0, 0);
        trial_req.orig_x = rand_coord();
        trial_req.orig_y = rand_coord();
        if (k < 4) begin
          trial_req.pivot_x = k[0] ? C_MAX : '0;
          trial_req.pivot_y = k[1] ? C_MAX : '0;
        end else begin
          trial_req.pivot_x = rand_coord();
          trial_req.pivot_y = rand_coord();
        end
        trial = plan_pose;
        unused = rotate_step(trial, trial_req, hit);
        ax = longint'(trial.off_x);
        ay = longint'(trial.off_y);
        score = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay);
        if (score > best_score) begin
          best_score = score;
          best_req   = trial_req;
        end
      end
      queue_req(best_req);
      if (plan_clamped) sat_seen = 1'b1;
      if (sat_seen) sat_tail++;
    end

    while (vertex_q.size() < N_ITEMS) add_random_frame();
    n_items = vertex_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (vertex_q.size() != 0 || s_tvalid || expected_vertices.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d vertex requests, %0d with frame start, %0d results checked",
             n_sent, n_frames, n_rcv);
    $display("%0d results clipped, %0d frame steps clamped the offset", n_clipped, n_clamps);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // sender: predicts on each accepted request, then offers the next one or idles
  always @(posedge clk_i) begin : drive_requests
    vertex_req_t nxt;
    vertex_res_t res;
    bit          hit;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        res = rotate_step(live_pose, cur_req, hit);
        expected_vertices.push_back(res);
        n_sent++;
        n_frames += int'(cur_req.frame_start);
        n_clamps += int'(hit);
      end
      // valid is only withdrawn once the current request has gone
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (hold_left == 0 && idle_allowed(n_sent) && $urandom_range(0, 9) == 0) begin
          src_gap  <= $urandom_range(0, 13);
          s_tvalid <= 1'b0;
        end else if (vertex_q.size() != 0) begin
          nxt      = vertex_q.pop_front();
          cur_req  <= nxt;
          s_tvalid <= 1'b1;
          s_tdata  <= {nxt.orig_y, nxt.orig_x, nxt.pivot_y, nxt.pivot_x};
          s_tuser  <= nxt.frame_start;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each accepted result against the oldest prediction
  always @(posedge clk_i) begin : check_results
    vertex_res_t             want;
    logic signed [OUT_W-1:0] got_x, got_y;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got_x = m_tdata[OUT_W-1:0];
        got_y = m_tdata[2*OUT_W-1:OUT_W];
        if (expected_vertices.size() == 0) begin
          $error("result with no request outstanding: out_x %0d out_y %0d", got_x, got_y);
          n_fail++;
        end else begin
          want = expected_vertices.pop_front();
          n_rcv++;
          n_clipped += int'(want.clipped);
          if (got_x !== want.out_x) begin
            $error("out_x mismatch: expected %0d, got %0d", want.out_x, got_x);
            n_fail++;
          end
          if (got_y !== want.out_y) begin
            $error("out_y mismatch: expected %0d, got %0d", want.out_y, got_y);
            n_fail++;
          end
          if (m_tuser !== want.clipped) begin
            $error("clipped mismatch: expected %0b, got %0b", want.clipped, m_tuser);
            n_fail++;
          end
        end
      end
      // one long hold-off lets the pipeline fill and push back on the sender
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (!hold_done && n_rcv >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES - 1;
        hold_done <= 1'b1;
        m_tready  <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (idle_allowed(n_rcv) && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", stall_cycles);
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

// ===== files.f =====
sv/ipr_pkg.sv
sv/ipr_rotate.sv
sv/ipr_vertex_out.sv
sv/incremental_pivot_rotation_unit.sv
test/incremental_pivot_rotation_unit_tb.sv
